[sv/rthi_pkg.sv]
// Package: sizes, types, codes and hash helpers for the record table.
`default_nettype none
package rthi_pkg;

  localparam int DEPTH = 1024;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;

  localparam logic [31:0] DUMMY_ADDR = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_FIND  = 3'd1,
    OP_BUILD = 3'd2,
    OP_SLOT  = 3'd3,
    OP_REC   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND_RD, S_FIND_CMP, S_CLEAR, S_B_RD, S_B_HOME, S_B_SLOT,
    S_B_CHAIN, S_B_PROBE, S_B_PUT, S_REC_RD, S_REC_OUT, S_SLOT_OUT, S_RESP
  } state_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] target;
    logic [31:0] domain;
    logic [15:0] kind;
  } entry_t;

  typedef struct packed {
    logic [AW-1:0] rec;
    logic [AW-1:0] link;
  } slot_t;

  // ELF hash over the four address bytes, low byte first
  function automatic logic [31:0] elf_hash(input logic [31:0] key);
    logic [31:0] h;
    logic [31:0] g;
    h = '0;
    for (int b = 0; b < 4; b++) begin
      h = (h << 4) + {24'd0, key[8*b +: 8]};
      g = h & 32'hF000_0000;
      if (g != '0) h = h ^ (g >> 24);
      h = h & ~g;
    end
    return h;
  endfunction

  // smallest power of two not below v (v >= 1)
  function automatic logic [CW-1:0] pow2_at_least(input logic [CW-1:0] v);
    logic [CW-1:0] p;
    logic [CW-1:0] cand;
    p = '0;
    for (int i = CW - 1; i >= 0; i--) begin
      cand = CW'(1) << i;
      if (cand >= v) p = cand;
    end
    return p;
  endfunction

  // masked slot number, slot 0 folds to slot 1
  function automatic logic [AW-1:0] home_slot(input logic [AW-1:0] v,
                                              input logic [AW-1:0] mask);
    logic [AW-1:0] s;
    s = v & mask;
    return (s == '0) ? AW'(1) : s;
  endfunction

endpackage
`default_nettype wire

[sv/rthi_if.sv]
// Interfaces: request and response channels of the record table.
`default_nettype none
interface rthi_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] addr;
  logic [31:0] target;
  logic [31:0] domain_size;
  logic [15:0] kind;
  logic [9:0]  position;
  modport source (output valid, op, addr, target, domain_size, kind, position,
                  input ready);
  modport sink (input valid, op, addr, target, domain_size, kind, position,
                output ready);
endinterface

interface rthi_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [10:0] result_index;
  logic [9:0]  slot_record;
  logic [9:0]  slot_next;
  logic [31:0] rec_addr;
  logic [31:0] rec_target;
  logic [31:0] rec_domain;
  logic [15:0] rec_kind;
  logic [9:0]  entry_count;
  modport source (output valid, status, result_index, slot_record, slot_next,
                  rec_addr, rec_target, rec_domain, rec_kind, entry_count,
                  input ready);
  modport sink (input valid, status, result_index, slot_record, slot_next,
                rec_addr, rec_target, rec_domain, rec_kind, entry_count,
                output ready);
endinterface
`default_nettype wire

[sv/rthi_entry_mem.sv]
// Record store: one write port, one registered read port.
`default_nettype none
module rthi_entry_mem (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [rthi_pkg::AW-1:0] waddr,
  input  wire rthi_pkg::entry_t      wdata,
  input  wire logic [rthi_pkg::AW-1:0] raddr,
  output rthi_pkg::entry_t           rdata
);
  import rthi_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/rthi_slot_mem.sv]
// Hash index slot store: one write port, one registered read port.
`default_nettype none
module rthi_slot_mem (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [rthi_pkg::AW-1:0] waddr,
  input  wire rthi_pkg::slot_t       wdata,
  input  wire logic [rthi_pkg::AW-1:0] raddr,
  output rthi_pkg::slot_t            rdata
);
  import rthi_pkg::*;

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/record_table_with_hash_index.sv]
// Top level: record table with a coalesced hash index, run by one sequencer.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | op, addr, target, domain_size, kind, position
//  rsp     | out | valid/ready   | status, result_index, slot_*, rec_*, entry_count
//
// One item at a time; req.ready is high only while the sequencer is idle.
// Add, unknown ops and out-of-range reads go straight to the response state;
// slot and record reads first read their store. Find walks the entries one by
// one through the entry store read port. Build clears the L index slots (L =
// index length), then puts each record on its home slot if free, else follows
// the chain to its end and probes for a free slot (slot store read port).
// Reset is synchronous; no clearing pass after reset. A stalled rsp holds its
// item in the output register; the next item is still taken meanwhile.
`default_nettype none
module record_table_with_hash_index (
  input wire logic clk,
  input wire logic rst,
  rthi_in_if.sink   req,
  rthi_out_if.source rsp
);
  import rthi_pkg::*;

  state_t state, state_next;

  // captured item
  logic [31:0]   addr_q;
  logic [AW-1:0] pos_q;

  // table bookkeeping
  logic [CW-1:0] next_free, next_free_next;
  logic [CW-1:0] index_length, index_length_next;

  // walk registers: r is record/clear counter, s the current slot
  logic [CW-1:0] r, r_next;
  logic [AW-1:0] s, s_next;
  logic [AW-1:0] last, last_next;
  logic [AW-1:0] last_rec, last_rec_next;
  logic [CW-1:0] guard, guard_next;

  // pending result
  logic [1:0]    res_status, res_status_next;
  logic [CW-1:0] res_index, res_index_next;
  slot_t         res_slot, res_slot_next;
  entry_t        res_rec, res_rec_next;

  // store ports
  logic          e_we;
  entry_t        e_wdata;
  logic [AW-1:0] e_raddr;
  entry_t        e_rdata;
  logic          t_we;
  logic [AW-1:0] t_waddr;
  slot_t         t_wdata;
  slot_t         t_rdata;

  logic [AW-1:0] mask;
  logic [31:0]   hash;
  logic [31:0]   cmp_addr;
  logic          accept;
  logic          load_out;

  assign mask     = AW'(index_length - CW'(1));
  assign hash     = elf_hash(e_rdata.addr);
  assign cmp_addr = (r == '0) ? DUMMY_ADDR : e_rdata.addr;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign load_out  = (state == S_RESP) && (!rsp.valid || rsp.ready);

  assign e_wdata = '{addr: req.addr, target: req.target,
                     domain: req.domain_size, kind: req.kind};

  rthi_entry_mem u_entry (
    .clk, .we(e_we), .waddr(next_free[AW-1:0]), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  // slot read address follows s_next, so t_rdata always shows slot s
  rthi_slot_mem u_slot (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(s_next), .rdata(t_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      next_free    <= CW'(1);
      index_length <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      state        <= state_next;
      next_free    <= next_free_next;
      index_length <= index_length_next;
      if (load_out) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_q <= req.addr;
      pos_q  <= req.position;
    end
    r          <= r_next;
    s          <= s_next;
    last       <= last_next;
    last_rec   <= last_rec_next;
    guard      <= guard_next;
    res_status <= res_status_next;
    res_index  <= res_index_next;
    res_slot   <= res_slot_next;
    res_rec    <= res_rec_next;
    if (load_out) begin
      rsp.status       <= res_status;
      rsp.result_index <= res_index;
      rsp.slot_record  <= res_slot.rec;
      rsp.slot_next    <= res_slot.link;
      rsp.rec_addr     <= res_rec.addr;
      rsp.rec_target   <= res_rec.target;
      rsp.rec_domain   <= res_rec.domain;
      rsp.rec_kind     <= res_rec.kind;
      rsp.entry_count  <= AW'(next_free - CW'(1));
    end
  end

  always_comb begin
    state_next        = state;
    next_free_next    = next_free;
    index_length_next = index_length;
    r_next            = r;
    s_next            = s;
    last_next         = last;
    last_rec_next     = last_rec;
    guard_next        = guard;
    res_status_next   = res_status;
    res_index_next    = res_index;
    res_slot_next     = res_slot;
    res_rec_next      = res_rec;
    e_we              = 1'b0;
    e_raddr           = r[AW-1:0];
    t_we              = 1'b0;
    t_waddr           = s;
    t_wdata           = '{rec: r[AW-1:0], link: '0};

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_status_next = ST_OK;
          res_index_next  = '0;
          res_slot_next   = '0;
          res_rec_next    = '0;
          r_next          = '0;
          state_next      = S_RESP;
          unique case (req.op)
            OP_ADD: begin
              if (next_free >= CW'(DEPTH)) begin
                res_status_next = ST_FULL;
              end else begin
                e_we           = 1'b1;
                res_index_next = next_free;
                next_free_next = next_free + CW'(1);
              end
            end
            OP_FIND:  state_next = S_FIND_RD;
            OP_BUILD: begin
              index_length_next = pow2_at_least(next_free);
              state_next        = S_CLEAR;
            end
            OP_SLOT: begin
              if (CW'(req.position) < index_length) begin
                s_next     = req.position;
                state_next = S_SLOT_OUT;
              end else begin
                res_status_next = ST_NOTFOUND;
              end
            end
            OP_REC: begin
              if (CW'(req.position) < next_free) state_next = S_REC_RD;
              else res_status_next = ST_NOTFOUND;
            end
            default: ;
          endcase
        end
      end

      S_FIND_RD: state_next = S_FIND_CMP;

      S_FIND_CMP: begin
        if (cmp_addr == addr_q) begin
          res_index_next = r;
          state_next     = S_RESP;
        end else if (r + CW'(1) >= next_free) begin
          res_status_next = ST_NOTFOUND;
          state_next      = S_RESP;
        end else begin
          r_next     = r + CW'(1);
          state_next = S_FIND_RD;
        end
      end

      // wipe slots 0 .. L-1
      S_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = r[AW-1:0];
        t_wdata = '0;
        if (r + CW'(1) >= index_length) begin
          res_index_next = index_length;
          if (next_free > CW'(1)) begin
            r_next     = CW'(1);
            state_next = S_B_RD;
          end else begin
            state_next = S_RESP;
          end
        end else begin
          r_next = r + CW'(1);
        end
      end

      S_B_RD: state_next = S_B_HOME;

      S_B_HOME: begin
        s_next     = home_slot(hash[AW-1:0], mask);
        state_next = S_B_SLOT;
      end

      S_B_SLOT: begin
        guard_next = '0;
        if (t_rdata.rec == '0) begin
          t_we = 1'b1;
          r_next = r + CW'(1);
          state_next = (r + CW'(1) < next_free) ? S_B_RD : S_RESP;
        end else begin
          state_next = S_B_CHAIN;
        end
      end

      // follow the chain to its end
      S_B_CHAIN: begin
        if (t_rdata.link != '0 && guard < index_length) begin
          s_next     = t_rdata.link;
          guard_next = guard + CW'(1);
        end else begin
          last_next     = s;
          last_rec_next = t_rdata.rec;
          s_next        = home_slot(s + AW'(1), mask);
          guard_next    = '0;
          state_next    = S_B_PROBE;
        end
      end

      // linear probe for a free slot, then link it from the chain end
      S_B_PROBE: begin
        if (t_rdata.rec != '0 && guard < index_length) begin
          s_next     = home_slot(s + AW'(1), mask);
          guard_next = guard + CW'(1);
        end else begin
          t_we       = 1'b1;
          t_waddr    = last;
          t_wdata    = '{rec: last_rec, link: s};
          state_next = S_B_PUT;
        end
      end

      S_B_PUT: begin
        t_we       = 1'b1;
        r_next     = r + CW'(1);
        state_next = (r + CW'(1) < next_free) ? S_B_RD : S_RESP;
      end

      S_REC_RD: begin
        e_raddr    = pos_q;
        state_next = S_REC_OUT;
      end

      S_REC_OUT: begin
        // entry 0 is the dummy: fixed address, other fields zero
        if (pos_q == '0) res_rec_next = '{addr: DUMMY_ADDR, default: '0};
        else res_rec_next = e_rdata;
        state_next = S_RESP;
      end

      S_SLOT_OUT: begin
        res_slot_next = t_rdata;
        state_next    = S_RESP;
      end

      S_RESP: begin
        if (load_out) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[test/testbench.sv]
// Testbench for the record table with hash index: directed table, then random checked items.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import rthi_pkg::*;

  // Op codes beyond the defined set; the block must answer them with status OK, zero results and the entry count.
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;
  localparam int NSLOT = 2 * DEPTH;
  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam int N_RANDOM = 1875;

  logic clk;
  logic rst;

  rthi_in_if  req_ch ();
  rthi_out_if rsp_ch ();

  record_table_with_hash_index u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  // One request item as the sender offers it.
  typedef struct {
    logic [2:0]  op;
    logic [31:0] addr;
    logic [31:0] target;
    logic [31:0] domain;
    logic [15:0] kind;
    logic [9:0]  position;
  } req_item_t;

  // One response item; dummy_rec marks a read of entry 0, whose payload
  // fields other than the address were never written.
  typedef struct {
    logic [1:0]  status;
    logic [10:0] result_index;
    logic [9:0]  slot_record;
    logic [9:0]  slot_next;
    logic [31:0] rec_addr;
    logic [31:0] rec_target;
    logic [31:0] rec_domain;
    logic [15:0] rec_kind;
    logic [9:0]  entry_count;
    bit          dummy_rec;
  } rsp_item_t;

  // Directed row: the item, and where it is obvious, the answer typed in.
  typedef struct {
    logic [2:0]  op;
    logic [31:0] addr;
    logic [31:0] target;
    logic [31:0] domain;
    logic [15:0] kind;
    logic [9:0]  position;
    bit          typed;
    logic [1:0]  status;
    logic [10:0] result_index;
    logic [9:0]  entry_count;
  } dir_row_t;

  // Shadow copy of the table and the index.
  logic [31:0] tbl_addr   [DEPTH];
  logic [31:0] tbl_target [DEPTH];
  logic [31:0] tbl_domain [DEPTH];
  logic [15:0] tbl_kind   [DEPTH];
  int          tbl_next;
  int          hx_rec  [NSLOT];
  int          hx_link [NSLOT];
  int          hx_len;

  rsp_item_t pending_rsp[$];
  int        n_errors;
  int        tx_idle_pct;
  int        rx_idle_pct;
  int        rx_hold;
  longint    n_cycles;

  // ---------------------------------------------------------------- clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ------------------------------------------------------- run-time limit
  initial begin
    n_cycles = 0;
    forever begin
      @(posedge clk);
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------- predictor
  // ELF hash, low address byte first.
  function automatic logic [31:0] elf_of(input logic [31:0] key);
    logic [31:0] acc;
    logic [31:0] top;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      acc = {acc[27:0], 4'h0} + 32'(key[8*i +: 8]);
      top = {acc[31:28], 28'h0};
      acc = (acc ^ (top >> 24)) & ~top;
    end
    return acc;
  endfunction

  // Slot within the index; slot 0 is never used and folds to slot 1.
  function automatic int fold_slot(input int v, input int len);
    int s;
    s = v & (len - 1);
    return (s == 0) ? 1 : s;
  endfunction

  function automatic void rebuild_index();
    int len;
    int s;
    int tail;
    int hops;
    len = 1;
    while (len < tbl_next) len = len * 2;
    for (int i = 0; i < NSLOT; i++) begin
      hx_rec[i]  = 0;
      hx_link[i] = 0;
    end
    hx_len = len;
    for (int r = 1; r < tbl_next; r++) begin
      s = fold_slot(int'(elf_of(tbl_addr[r]) & 32'h7FFF_FFFF), len);
      if (hx_rec[s] != 0) begin
        // walk to the chain tail, then probe upward for a free slot
        hops = 0;
        while (hx_link[s] != 0 && hops < len) begin
          s = hx_link[s] % NSLOT;
          hops++;
        end
        tail = s;
        s = fold_slot(s + 1, len);
        hops = 0;
        while (hx_rec[s] != 0 && hops < len) begin
          s = fold_slot(s + 1, len);
          hops++;
        end
        hx_link[tail] = s;
      end
      hx_rec[s]  = r;
      hx_link[s] = 0;
    end
  endfunction

  function automatic rsp_item_t table_answer(input req_item_t it);
    rsp_item_t a;
    int        hit;
    a = '{default: '0};
    case (it.op)
      OP_ADD: begin
        if (tbl_next >= DEPTH) begin
          a.status = ST_FULL;
        end else begin
          tbl_addr[tbl_next]   = it.addr;
          tbl_target[tbl_next] = it.target;
          tbl_domain[tbl_next] = it.domain;
          tbl_kind[tbl_next]   = it.kind;
          a.result_index = 11'(tbl_next);
          tbl_next++;
        end
      end
      OP_FIND: begin
        hit = -1;
        for (int r = 0; r < tbl_next; r++)
          if (hit < 0 && tbl_addr[r] == it.addr) hit = r;
        if (hit >= 0) a.result_index = 11'(hit);
        else a.status = ST_NOTFOUND;
      end
      OP_BUILD: begin
        rebuild_index();
        a.result_index = 11'(hx_len);
      end
      OP_SLOT: begin
        if (int'(it.position) < hx_len) begin
          a.slot_record = 10'(hx_rec[it.position]);
          a.slot_next   = 10'(hx_link[it.position]);
        end else begin
          a.status = ST_NOTFOUND;
        end
      end
      OP_REC: begin
        if (int'(it.position) < tbl_next) begin
          a.rec_addr  = tbl_addr[it.position];
          a.dummy_rec = (it.position == '0);
          if (!a.dummy_rec) begin
            a.rec_target = tbl_target[it.position];
            a.rec_domain = tbl_domain[it.position];
            a.rec_kind   = tbl_kind[it.position];
          end
        end else begin
          a.status = ST_NOTFOUND;
        end
      end
      default: ;
    endcase
    a.entry_count = 10'(tbl_next - 1);
    return a;
  endfunction

  // -------------------------------------------------------------- receiver
  // Random back-pressure; rx_hold forces a long stall when set.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold      <= rx_hold - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // Compare every accepted response with the oldest expectation.
  always @(posedge clk) begin
    rsp_item_t w;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with nothing expected: status %h index %h", $time,
                 rsp_ch.status, rsp_ch.result_index);
        n_errors++;
      end else begin
        w = pending_rsp.pop_front();
        check_field("status", w.status, rsp_ch.status);
        check_field("result_index", w.result_index, rsp_ch.result_index);
        check_field("slot_record", w.slot_record, rsp_ch.slot_record);
        check_field("slot_next", w.slot_next, rsp_ch.slot_next);
        check_field("rec_addr", w.rec_addr, rsp_ch.rec_addr);
        if (!w.dummy_rec) begin
          check_field("rec_target", w.rec_target, rsp_ch.rec_target);
          check_field("rec_domain", w.rec_domain, rsp_ch.rec_domain);
          check_field("rec_kind", w.rec_kind, rsp_ch.rec_kind);
        end
        check_field("entry_count", w.entry_count, rsp_ch.entry_count);
      end
    end
  end

  // ---------------------------------------------------------------- sender
  // Offer one item, hold it until taken, then queue what it should return.
  // A typed answer replaces status, index and count of the predicted one.
  task automatic offer(input req_item_t it, input bit typed, input logic [1:0] t_status,
                       input logic [10:0] t_index, input logic [9:0] t_count);
    rsp_item_t want;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= it.op;
    req_ch.addr        <= it.addr;
    req_ch.target      <= it.target;
    req_ch.domain_size <= it.domain;
    req_ch.kind        <= it.kind;
    req_ch.position    <= it.position;
    do @(posedge clk); while (!req_ch.ready);
    want = table_answer(it);
    if (typed) begin
      want.status       = t_status;
      want.result_index = t_index;
      want.entry_count  = t_count;
    end
    pending_rsp.push_back(want);
  endtask

  // Hold the sender until every outstanding response has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] wide_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Random item, mostly adds so the table fills and hits the full case.
  // Builds and finds get slow as the table grows, so builds thin out then.
  function automatic req_item_t random_item();
    req_item_t it;
    int        pick;
    pick = $urandom_range(99);
    it.target   = wide_value();
    it.domain   = wide_value();
    it.kind     = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom());
    it.position = 10'($urandom());
    it.addr     = $urandom();
    if (pick < 55) begin
      it.op = OP_ADD;
      case ($urandom_range(9))
        // few distinct low bytes: dense hash collisions and long chains
        0, 1: it.addr = {24'h0, 8'($urandom_range(15))} << (8 * $urandom_range(3));
        2: it.addr = tbl_addr[$urandom_range(tbl_next - 1)];
        3: it.addr = DUMMY_ADDR;
        default: ;
      endcase
    end else if (pick < 70) begin
      it.op = OP_FIND;
      if ($urandom_range(9) < 6) it.addr = tbl_addr[$urandom_range(tbl_next - 1)];
      else if ($urandom_range(9) == 0) it.addr = DUMMY_ADDR;
    end else if (pick < 72 && (tbl_next < 300 || $urandom_range(9) == 0)) begin
      it.op = OP_BUILD;
    end else if (pick < 85) begin
      it.op = OP_SLOT;
      if (hx_len > 0 && $urandom_range(9) < 8)
        it.position = 10'($urandom_range(hx_len - 1));
    end else if (pick < 97) begin
      it.op = OP_REC;
      if ($urandom_range(9) < 8) it.position = 10'($urandom_range(tbl_next - 1));
    end else begin
      it.op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
    end
    return it;
  endfunction

  dir_row_t dir_tab [] = '{
    // after reset: dummy entry only, no index yet
    '{OP_REC,   32'h0, 32'h0, 32'h0, 16'h0, 10'd0,    1, ST_OK,       11'd0, 10'd0},
    '{OP_FIND,  DUMMY_ADDR, 32'h0, 32'h0, 16'h0, 10'd0, 1, ST_OK,     11'd0, 10'd0},
    '{OP_FIND,  32'h0, 32'h0, 32'h0, 16'h0, 10'd0,    1, ST_NOTFOUND, 11'd0, 10'd0},
    '{OP_REC,   32'h0, 32'h0, 32'h0, 16'h0, 10'd1,    1, ST_NOTFOUND, 11'd0, 10'd0},
    '{OP_SLOT,  32'h0, 32'h0, 32'h0, 16'h0, 10'd0,    1, ST_NOTFOUND, 11'd0, 10'd0},
    // index over an empty table has length one
    '{OP_BUILD, 32'h0, 32'h0, 32'h0, 16'h0, 10'd0,    1, ST_OK,       11'd1, 10'd0},
    '{OP_SLOT,  32'h0, 32'h0, 32'h0, 16'h0, 10'd0,    1, ST_OK,       11'd0, 10'd0},
    // field extremes
    '{OP_ADD,   32'h0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 10'd0, 1, ST_OK, 11'd1, 10'd1},
    '{OP_ADD,   DUMMY_ADDR, 32'h0, 32'hFFFF_FFFF, 16'h0, 10'd0, 1, ST_OK, 11'd2, 10'd2},
    '{OP_ADD,   32'h1234_5678, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'h8001, 10'h3FF,
      1, ST_OK, 11'd3, 10'd3},
    '{OP_ADD,   32'h7800_0000, 32'h1, 32'h8000_0000, 16'h7FFE, 10'h155, 0, ST_OK, 0, 0},
    // the dummy wins a find of all ones
    '{OP_FIND,  DUMMY_ADDR, 32'h0, 32'h0, 16'h0, 10'd0, 1, ST_OK,     11'd0, 10'd4},
    '{OP_FIND,  32'h0, 32'h0, 32'h0, 16'h0, 10'd0,    1, ST_OK,       11'd1, 10'd4},
    '{OP_FIND,  32'h1234_5678, 32'h0, 32'h0, 16'h0, 10'd0, 0, ST_OK, 0, 0},
    '{OP_REC,   32'h0, 32'h0, 32'h0, 16'h0, 10'd2,    0, ST_OK, 0, 0},
    '{OP_REC,   32'h0, 32'h0, 32'h0, 16'h0, 10'd4,    0, ST_OK, 0, 0},
    '{OP_REC,   32'h0, 32'h0, 32'h0, 16'h0, 10'h3FF,  1, ST_NOTFOUND, 11'd0, 10'd4},
    // unused op codes do nothing
    '{OP_SPARE_A, '1, '1, '1, '1, '1,                  1, ST_OK,       11'd0, 10'd4},
    '{OP_SPARE_B, '1, '1, '1, '1, '1,                  1, ST_OK,       11'd0, 10'd4},
    '{OP_SPARE_C, '1, '1, '1, '1, '1,                  1, ST_OK,       11'd0, 10'd4},
    // five entries in use, so the index grows to eight slots
    '{OP_BUILD, 32'h0, 32'h0, 32'h0, 16'h0, 10'd0,    1, ST_OK,       11'd8, 10'd4},
    '{OP_SLOT,  32'h0, 32'h0, 32'h0, 16'h0, 10'd1,    0, ST_OK, 0, 0},
    '{OP_SLOT,  32'h0, 32'h0, 32'h0, 16'h0, 10'd3,    0, ST_OK, 0, 0},
    '{OP_SLOT,  32'h0, 32'h0, 32'h0, 16'h0, 10'd7,    0, ST_OK, 0, 0},
    '{OP_SLOT,  32'h0, 32'h0, 32'h0, 16'h0, 10'd8,    1, ST_NOTFOUND, 11'd0, 10'd4}
  };

  // -------------------------------------------------------------- stimulus
  initial begin
    req_item_t it;
    n_errors    = 0;
    tbl_next    = 1;
    hx_len      = 0;
    tbl_addr[0] = DUMMY_ADDR;
    for (int i = 0; i < NSLOT; i++) begin
      hx_rec[i]  = 0;
      hx_link[i] = 0;
    end
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold     = 0;
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.op          = OP_ADD;
    req_ch.addr        = '0;
    req_ch.target      = '0;
    req_ch.domain_size = '0;
    req_ch.kind        = '0;
    req_ch.position    = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, idling on both sides, the receiver more than the sender
    tx_idle_pct = 30;
    rx_idle_pct = 68;
    foreach (dir_tab[i]) begin
      it = '{dir_tab[i].op, dir_tab[i].addr, dir_tab[i].target, dir_tab[i].domain,
             dir_tab[i].kind, dir_tab[i].position};
      offer(it, dir_tab[i].typed, dir_tab[i].status, dir_tab[i].result_index,
            dir_tab[i].entry_count);
    end

    // random items in three thirds: sender idles less than receiver, then
    // the reverse, then no idling at all
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        drain();  // sender waits out every response before switching sides
        tx_idle_pct = 68;
        rx_idle_pct = 30;
      end else if (n == 2 * N_RANDOM / 3) begin
        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // long receiver stall while the sender keeps offering: output
        // register fills, then the block refuses input
        @(negedge clk);
        rx_hold = 400;
      end
      offer(random_item(), 0, ST_OK, '0, '0);
    end
    req_ch.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
sv/rthi_pkg.sv
sv/rthi_if.sv
sv/rthi_entry_mem.sv
sv/rthi_slot_mem.sv
sv/record_table_with_hash_index.sv
test/testbench.sv
